>>> rtl/core/utf8sd_pkg.sv
// Package for the UTF-8 stream decoder: field widths, code point constants,
// decoder state and result types shared by the decoder core and the top level.
// No dependencies.
`timescale 1ns / 1ps

package utf8sd_pkg;

    localparam int BYTE_W = 8;
    localparam int CP_W   = 21;

    // Default depth of the result queue; must be a power of two, at least 2.
    localparam int QUEUE_DEPTH = 4;

    localparam logic [CP_W-1:0] REPL_CP      = 21'h00FFFD;
    localparam logic [CP_W-1:0] MIN_3BYTE_CP = 21'h000800;
    localparam logic [CP_W-1:0] SURR_LO_CP   = 21'h00D800;
    localparam logic [CP_W-1:0] SURR_HI_CP   = 21'h00E000;
    localparam logic [CP_W-1:0] MIN_4BYTE_CP = 21'h010000;
    localparam logic [CP_W-1:0] MAX_CP_LIMIT = 21'h110000;

    localparam logic [BYTE_W-1:0] CONT_LO    = 8'h80;
    localparam logic [BYTE_W-1:0] CONT_HI    = 8'hC0;
    localparam logic [BYTE_W-1:0] LEAD2_MIN  = 8'hC2;
    localparam logic [BYTE_W-1:0] LEAD3_MIN  = 8'hE0;
    localparam logic [BYTE_W-1:0] LEAD4_MIN  = 8'hF0;
    localparam logic [BYTE_W-1:0] LEAD4_BAD  = 8'hF5;

    localparam logic [2:0] SEQ_LEN_2 = 3'd2;
    localparam logic [2:0] SEQ_LEN_3 = 3'd3;
    localparam logic [2:0] SEQ_LEN_4 = 3'd4;

    typedef struct packed {
        logic [1:0]      remaining;
        logic [2:0]      length;
        logic [CP_W-1:0] acc;
        logic            forced;
    } seq_state_t;

    typedef struct packed {
        logic [CP_W-1:0] code_point;
        logic            is_replacement;
        logic            last_of_run;
    } result_t;

endpackage

>>> rtl/core/utf8sd_decoder.sv
// Decoder core: holds the pending multi-byte sequence and turns each accepted
// byte into zero, one or two results. Depends on utf8sd_pkg.
`timescale 1ns / 1ps

module utf8sd_decoder (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              in_accept,
    input  logic [utf8sd_pkg::BYTE_W-1:0]     in_byte,
    output logic [1:0]                        res_count,
    output utf8sd_pkg::result_t               res0,
    output utf8sd_pkg::result_t               res1
);

    utf8sd_pkg::seq_state_t state_reg;
    utf8sd_pkg::seq_state_t state_next;

    // Lead byte decoding, starting from an empty sequence.
    utf8sd_pkg::seq_state_t lead_state;
    logic                   lead_has_res;
    utf8sd_pkg::result_t    lead_res;

    logic                            is_cont;
    logic [utf8sd_pkg::CP_W-1:0]     acc_shift;
    logic [1:0]                      rem_dec;
    logic                            seq_bad;

    always_comb begin
        lead_state   = '0;
        lead_has_res = 1'b0;
        lead_res     = '0;
        lead_res.last_of_run = 1'b1;
        if (in_byte < utf8sd_pkg::CONT_LO) begin
            lead_has_res        = 1'b1;
            lead_res.code_point = {{(utf8sd_pkg::CP_W-utf8sd_pkg::BYTE_W){1'b0}}, in_byte};
        end else if (in_byte < utf8sd_pkg::LEAD2_MIN) begin
            lead_has_res            = 1'b1;
            lead_res.code_point     = utf8sd_pkg::REPL_CP;
            lead_res.is_replacement = 1'b1;
        end else if (in_byte < utf8sd_pkg::LEAD3_MIN) begin
            lead_state.length    = utf8sd_pkg::SEQ_LEN_2;
            lead_state.remaining = 2'd1;
            lead_state.acc       = {16'd0, in_byte[4:0]};
        end else if (in_byte < utf8sd_pkg::LEAD4_MIN) begin
            lead_state.length    = utf8sd_pkg::SEQ_LEN_3;
            lead_state.remaining = 2'd2;
            lead_state.acc       = {17'd0, in_byte[3:0]};
        end else begin
            lead_state.length    = utf8sd_pkg::SEQ_LEN_4;
            lead_state.remaining = 2'd3;
            lead_state.acc       = {18'd0, in_byte[2:0]};
            lead_state.forced    = (in_byte >= utf8sd_pkg::LEAD4_BAD);
        end
    end

    assign is_cont   = (in_byte >= utf8sd_pkg::CONT_LO) && (in_byte < utf8sd_pkg::CONT_HI);
    assign acc_shift = {state_reg.acc[utf8sd_pkg::CP_W-7:0], in_byte[5:0]};
    assign rem_dec   = state_reg.remaining - 2'd1;

    // Judge a completed sequence; any length other than two or three is
    // treated as a four-byte sequence.
    always_comb begin
        case (state_reg.length)
            utf8sd_pkg::SEQ_LEN_2: seq_bad = 1'b0;
            utf8sd_pkg::SEQ_LEN_3: seq_bad = (acc_shift < utf8sd_pkg::MIN_3BYTE_CP)
                || ((acc_shift >= utf8sd_pkg::SURR_LO_CP)
                    && (acc_shift < utf8sd_pkg::SURR_HI_CP));
            default: seq_bad = state_reg.forced
                || (acc_shift < utf8sd_pkg::MIN_4BYTE_CP)
                || (acc_shift >= utf8sd_pkg::MAX_CP_LIMIT);
        endcase
    end

    always_comb begin
        state_next = state_reg;
        res_count  = 2'd0;
        res0       = lead_res;
        res1       = lead_res;
        if (state_reg.remaining == 2'd0) begin
            state_next = lead_state;
            res_count  = lead_has_res ? 2'd1 : 2'd0;
        end else if (is_cont) begin
            state_next.acc       = acc_shift;
            state_next.remaining = rem_dec;
            if (rem_dec == 2'd0) begin
                state_next              = '0;
                res_count               = 2'd1;
                res0.code_point         = seq_bad ? utf8sd_pkg::REPL_CP : acc_shift;
                res0.is_replacement     = seq_bad;
                res0.last_of_run        = 1'b1;
            end
        end else begin
            // The pending sequence is cut short; the byte then starts over.
            state_next          = lead_state;
            res0.code_point     = utf8sd_pkg::REPL_CP;
            res0.is_replacement = 1'b1;
            res0.last_of_run    = !lead_has_res;
            res_count           = lead_has_res ? 2'd2 : 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= '0;
        end else if (in_accept) begin
            state_reg <= state_next;
        end
    end

endmodule

>>> rtl/core/utf8sd_outq.sv
// Result queue: takes up to two results per cycle from the decoder and
// presents one per cycle on the output channel while out_ready is high. Depends on utf8sd_pkg.
`timescale 1ns / 1ps

module utf8sd_outq #(
    parameter int DEPTH = utf8sd_pkg::QUEUE_DEPTH
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic [1:0]             push_count,
    input  utf8sd_pkg::result_t    push0,
    input  utf8sd_pkg::result_t    push1,
    output logic                   has_room,
    output logic                   out_valid,
    input  logic                   out_ready,
    output utf8sd_pkg::result_t    out_data
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    utf8sd_pkg::result_t entry_reg [DEPTH];

    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [PTR_W-1:0] wr_ptr_plus1;
    logic             pop;

    assign pop          = out_valid && out_ready;
    assign out_valid    = (count_reg != '0);
    assign out_data     = entry_reg[rd_ptr_reg];
    // Room for the worst case of two results from one byte.
    assign has_room     = (count_reg <= CNT_W'(DEPTH - 2));
    assign wr_ptr_plus1 = wr_ptr_reg + PTR_W'(1);

    always_comb begin
        wr_ptr_next = wr_ptr_reg + PTR_W'(push_count);
        rd_ptr_next = rd_ptr_reg + PTR_W'(pop);
        count_next  = count_reg + CNT_W'(push_count) - CNT_W'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push_count != 2'd0) begin
            entry_reg[wr_ptr_reg] <= push0;
        end
        if (push_count == 2'd2) begin
            entry_reg[wr_ptr_plus1] <= push1;
        end
    end

endmodule

>>> rtl/core/utf8_stream_decoder.sv
// UTF-8 stream decoder: one byte in per cycle while s_ready is high, Unicode
// code points out. Built from utf8sd_decoder and utf8sd_outq; depends on utf8sd_pkg.
//
// Input channel: s_in_byte with s_valid/s_ready, one raw byte per transaction.
// Output channel: m_code_point, m_is_replacement, m_last_of_run with
// m_valid/m_ready, one result per transaction. A byte gives zero, one or two
// results; m_last_of_run marks the final result caused by a byte.
// Each result is queued when its byte is taken, behind any earlier results.
// Throughput: one byte per cycle while s_ready is high. The sequence state
// updates in the cycle a byte is accepted, so bytes may follow back to back.
// Results leave at one per cycle while m_ready is high, so a run of bytes
// that each give two results is limited by the output side.
// Stalls: results collect in a QUEUE_DEPTH-entry queue; s_ready stays high
// while two entries are free, and drops when the receiver holds m_ready low
// long enough that fewer than two are free. No result is lost or repeated.
// Reset: aresetn (synchronous, active low) drops any pending sequence and
// empties the queue.
`timescale 1ns / 1ps

module utf8_stream_decoder #(
    parameter int QUEUE_DEPTH = utf8sd_pkg::QUEUE_DEPTH
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [utf8sd_pkg::BYTE_W-1:0]     s_in_byte,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [utf8sd_pkg::CP_W-1:0]       m_code_point,
    output logic                              m_is_replacement,
    output logic                              m_last_of_run
);

    logic                in_accept;
    logic [1:0]          res_count;
    logic [1:0]          push_count;
    utf8sd_pkg::result_t res0;
    utf8sd_pkg::result_t res1;
    utf8sd_pkg::result_t out_data;

    assign in_accept  = s_valid && s_ready;
    assign push_count = in_accept ? res_count : 2'd0;

    utf8sd_decoder u_decoder (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_accept (in_accept),
        .in_byte   (s_in_byte),
        .res_count (res_count),
        .res0      (res0),
        .res1      (res1)
    );

    utf8sd_outq #(
        .DEPTH (QUEUE_DEPTH)
    ) u_outq (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_count (push_count),
        .push0      (res0),
        .push1      (res1),
        .has_room   (s_ready),
        .out_valid  (m_valid),
        .out_ready  (m_ready),
        .out_data   (out_data)
    );

    assign m_code_point     = out_data.code_point;
    assign m_is_replacement = out_data.is_replacement;
    assign m_last_of_run    = out_data.last_of_run;

endmodule
